[rtl/uida_pkg.sv]
// ----------------------------------------------------------------------------
// uida_pkg
// shared constants, types and the byte residue table of the id allocator
// ----------------------------------------------------------------------------
package uida_pkg;

  // number of identifiers handed out
  localparam int NUM_IDS  = 100;

  // used map is kept as rows of bits in a synchronous memory
  localparam int ROW_W    = 8;
  localparam int COL_W    = $clog2(ROW_W);
  localparam int NUM_ROWS = (NUM_IDS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int IDX_W    = ROW_AW + COL_W;

  // running sum and issue counter widths
  localparam int SUM_W    = (NUM_IDS > 2) ? $clog2(NUM_IDS) : 1;
  localparam int CNT_W    = $clog2(NUM_IDS + 1);

  // port field widths
  localparam int CHAR_W   = 8;
  localparam int ID_W     = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef logic [SUM_W-1:0] bmod_tbl_t [256];

  // residue of every byte value, built at elaboration
  function automatic bmod_tbl_t build_bmod_tbl();
    bmod_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = SUM_W'(i % NUM_IDS);
    end
    return t;
  endfunction

  localparam bmod_tbl_t BMOD_TBL = build_bmod_tbl();

endpackage : uida_pkg

[rtl/unique_id_hash_allocator.sv]
// ----------------------------------------------------------------------------
// unique_id_hash_allocator
// issues a unique identifier per name, probing linearly from an additive hash
// ----------------------------------------------------------------------------
// name end: a tlast byte goes to ST_SCAN, or to ST_DONE if the map is full
// throughput: one byte per cycle inside a name, none from a name end until the
//   fsm is back in ST_IDLE; the probe reads one 8-bit row of the used-map
//   memory per cycle, so the name end costs 1 row read plus one per fully
//   used row passed, and ST_DONE hands off the result once out_free is set
// reset: async active low; clears sum, counter, fsm, output valid and the row
//   valid bits, so the used map reads as all free at once (no clearing pass)
// ----------------------------------------------------------------------------
module unique_id_hash_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave side
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [uida_pkg::CHAR_W-1:0]  s_axis_tdata_i,  // [7:0] char_code
  input  logic                         s_axis_tlast_i,
  // master side
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [7:0]                   m_axis_tdata_o,  // [6:0] id, [7] zero
  output logic                         m_axis_tuser_o   // [0] full_res
);

  import uida_pkg::*;

  // fsm
  state_e state_q, state_d;

  // running hash and issue counter
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // probe position
  logic [ROW_AW-1:0] row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              first_q, first_d;   // first visit of the start row

  // pending result
  logic [IDX_W-1:0]  res_id_q, res_id_d;
  logic              res_full_q, res_full_d;

  // output register
  logic              m_valid_q, m_valid_d;
  logic [ID_W-1:0]   m_id_q, m_id_d;
  logic              m_full_q, m_full_d;

  // used-map memory, row valid bits stand in for a reset clear
  logic [ROW_W-1:0]  used_mem [NUM_ROWS];
  logic [ROW_W-1:0]  rd_data_q;
  logic [NUM_ROWS-1:0] row_vld_q, row_vld_d;
  logic [ROW_AW-1:0] rd_addr;
  logic              wr_en;
  logic [ROW_W-1:0]  wr_data;

  // datapath helpers
  logic              in_xfer;
  logic              out_free;
  logic              is_full;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_new;
  logic [IDX_W-1:0]  start_idx;
  logic [ROW_AW-1:0] next_row;
  logic [ROW_W-1:0]  row_eff;
  logic [ROW_W-1:0]  blocked;
  logic              hit;
  logic [COL_W-1:0]  hit_pos;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign is_full  = (cnt_q == CNT_W'(NUM_IDS));

  // sum plus byte residue stays below twice the modulus
  always_comb begin
    sum_add = {1'b0, sum_q} + {1'b0, BMOD_TBL[s_axis_tdata_i]};
    if (sum_add >= (SUM_W+1)'(NUM_IDS)) begin
      sum_new = SUM_W'(sum_add - (SUM_W+1)'(NUM_IDS));
    end else begin
      sum_new = SUM_W'(sum_add);
    end
  end

  assign start_idx = IDX_W'(sum_new);
  assign next_row  = (row_q == ROW_AW'(NUM_ROWS - 1)) ? '0 : row_q + 1'b1;

  // row under test: unwritten rows read as free
  assign row_eff = row_vld_q[row_q] ? rd_data_q : '0;

  // bits already used, below the start on the first visit, or past the last id
  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      blocked[j] = row_eff[j]
                || (first_q && (COL_W'(j) < col_q))
                || ({1'b0, row_q, COL_W'(j)} >= (IDX_W+1)'(NUM_IDS));
    end
  end

  // lowest free bit of the row
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (!blocked[j]) begin
        hit     = 1'b1;
        hit_pos = COL_W'(j);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && s_axis_tlast_i) begin
          state_d = is_full ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    s_axis_tready_o = 1'b0;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    first_d    = first_q;
    res_id_d   = res_id_q;
    res_full_d = res_full_q;
    row_vld_d  = row_vld_q;
    rd_addr    = row_q;
    wr_en      = 1'b0;
    wr_data    = row_eff | (ROW_W'(1) << hit_pos);
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_id_d     = m_id_q;
    m_full_d   = m_full_q;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        rd_addr         = start_idx[IDX_W-1:COL_W];
        if (in_xfer) begin
          if (s_axis_tlast_i) begin
            // name ends: hash restarts, probe begins at the sum
            sum_d      = '0;
            row_d      = start_idx[IDX_W-1:COL_W];
            col_d      = start_idx[COL_W-1:0];
            first_d    = 1'b1;
            res_id_d   = '0;
            res_full_d = is_full;
          end else begin
            sum_d = sum_new;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          wr_en            = 1'b1;
          row_vld_d[row_q] = 1'b1;
          cnt_d            = cnt_q + 1'b1;
          res_id_d         = {row_q, hit_pos};
          res_full_d       = 1'b0;
        end else begin
          // row fully used: read the next, wrapping at the end
          rd_addr = next_row;
          row_d   = next_row;
          first_d = 1'b0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_id_d    = ID_W'(res_id_q);
          m_full_d  = res_full_q;
        end
      end
      default: ;
    endcase
  end

  // used-map memory, registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      used_mem[row_q] <= wr_data;
    end
    rd_data_q <= used_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sum_q     <= '0;
      cnt_q     <= '0;
      row_vld_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      row_vld_q <= row_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    col_q      <= col_d;
    first_q    <= first_d;
    res_id_q   <= res_id_d;
    res_full_q <= res_full_d;
    m_id_q     <= m_id_d;
    m_full_q   <= m_full_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_id_q};
  assign m_axis_tuser_o  = m_full_q;

endmodule : unique_id_hash_allocator

[rtl/uida_checker.sv]
// ----------------------------------------------------------------------------
// uida_checker
// port-level checks of the id allocator, bound to the top level
// ----------------------------------------------------------------------------
module uida_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         s_axis_tlast_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [7:0]                   m_axis_tdata_o,  // [6:0] id, [7] zero
  input logic                         m_axis_tuser_o   // [0] full_res
);

  import uida_pkg::*;

  // stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // a full answer carries id zero
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 8'd0)
    else $error("full result with nonzero id");

  // an issued id lies in range
  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> {24'd0, m_axis_tdata_o} < NUM_IDS)
    else $error("issued id out of range");

  // a name end starts a probe or a full answer, input is held off the next cycle
  a_probe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input taken during probe");

  // no result once reset has been seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid in reset");

endmodule : uida_checker

bind unique_id_hash_allocator uida_checker u_uida_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

[tb/sv/tb_unique_id_hash_allocator.sv]
// ----------------------------------------------------------------------------
// tb_unique_id_hash_allocator
// streams names byte by byte into the id allocator and checks every issued id
// against an in-bench additive hash with linear probing, through the full map
// ----------------------------------------------------------------------------
module tb_unique_id_hash_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import uida_pkg::*;

  // one name byte as it travels on the slave side
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } name_byte_t;

  // one issued identifier as it should come out of the master side
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            full;
  } id_grant_t;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;

  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [CHAR_W-1:0] s_tdata = '0;
  logic              s_tlast = 1'b0;

  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;
  logic              m_tuser;

  // bytes waiting to be offered and grants waiting to come back
  name_byte_t        byte_q[$];
  id_grant_t         grant_q[$];

  // shadow copy of the allocator state
  int                hash_sum;
  bit [NUM_IDS-1:0]  id_used;
  int                ids_issued;

  // idle odds in percent, changed between traffic phases
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;

  int                err_cnt = 0;
  int                cycle_cnt = 0;

  unique_id_hash_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // fold one accepted byte into the hash; at the name end probe upward for a
  // free id, or report full and leave the map alone
  task automatic absorb_byte(input logic [CHAR_W-1:0] code, input logic last);
    int probe;
    id_grant_t grant;
    hash_sum = (hash_sum + int'(code)) % NUM_IDS;
    if (!last) return;
    probe = hash_sum;
    hash_sum = 0;
    if (ids_issued >= NUM_IDS) begin
      grant.id = '0;
      grant.full = 1'b1;
    end else begin
      while (id_used[probe]) probe = (probe + 1) % NUM_IDS;
      id_used[probe] = 1'b1;
      ids_issued++;
      grant.id = ID_W'(probe);
      grant.full = 1'b0;
    end
    grant_q.push_back(grant);
  endtask

  task automatic push_byte(input logic [CHAR_W-1:0] code, input logic last);
    name_byte_t b;
    b.code = code;
    b.last = last;
    byte_q.push_back(b);
  endtask

  // random name of the given length; zero and all-ones bytes come often
  task automatic push_rand_name(input int len);
    int pick;
    logic [CHAR_W-1:0] code;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(9);
      if (pick == 0) code = '0;
      else if (pick == 1) code = '1;
      else code = CHAR_W'($urandom);
      push_byte(code, i == len - 1);
    end
  endtask

  // fill one traffic phase with random names up to about n bytes
  task automatic push_rand_phase(input int n);
    int added;
    int len;
    added = 0;
    while (added < n) begin
      // mostly short names, now and then a long one
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
      push_rand_name(len);
      added += len;
    end
  endtask

  // driver: keeps a byte on the bus until its transaction completes, and
  // hands every accepted byte to the shadow allocator
  always @(posedge clk_i or negedge rst_ni) begin
    name_byte_t b;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) absorb_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          b = byte_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= b.code;
          s_tlast  <= b.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: every result transaction is matched against the oldest grant
  always @(posedge clk_i) begin
    id_grant_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result: id %0d full_res %0b", m_tdata[ID_W-1:0], m_tuser);
        err_cnt++;
      end else begin
        want = grant_q.pop_front();
        if (m_tdata[ID_W-1:0] !== want.id) begin
          $error("id: expected %0d, got %0d", want.id, m_tdata[ID_W-1:0]);
          err_cnt++;
        end
        if (m_tuser !== want.full) begin
          $error("full_res: expected %0b, got %0b", want.full, m_tuser);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    hash_sum = 0;
    id_used = '0;
    ids_issued = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // phase one: sender rarely idles, receiver mostly stalls
    tx_idle_pct = 8;
    rx_idle_pct = 86;

    // empty name lands on id 0
    push_byte(8'd0, 1'b1);
    // all-ones byte hashes to 55
    push_byte(8'd255, 1'b1);
    // zero bytes add nothing, so this collides with id 0 and moves to 1
    push_byte(8'd0, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd0, 1'b1);
    // several wraps of the sum: 1020 mod 100 = 20
    push_byte(8'd255, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd255, 1'b1);
    // exactly the modulus, back to 0, next free is 2
    push_byte(8'd100, 1'b1);
    // sum of 100 over two bytes, next free is 3
    push_byte(8'd99, 1'b0);
    push_byte(8'd1, 1'b1);
    // top id
    push_byte(8'd99, 1'b1);
    // 99 taken, probe wraps past the top to 4
    push_byte(8'd199, 1'b1);
    // alternating bit patterns, 255 again so 55 is taken and 56 is issued
    push_byte(8'haa, 1'b0);
    push_byte(8'h55, 1'b1);
    push_byte(8'h01, 1'b1);

    push_rand_phase(377);
    while (byte_q.size() != 0) @(negedge clk_i);

    // phase two: sender mostly idles, receiver rarely stalls
    tx_idle_pct = 86;
    rx_idle_pct = 8;
    push_rand_phase(377);
    while (byte_q.size() != 0) @(negedge clk_i);

    // phase three: full speed on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    push_rand_phase(376);
    while (byte_q.size() != 0 || s_tvalid || grant_q.size() != 0) @(negedge clk_i);

    // let any stray result show up
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule : tb_unique_id_hash_allocator

[files.f]
rtl/uida_pkg.sv
rtl/unique_id_hash_allocator.sv
rtl/uida_checker.sv
tb/sv/tb_unique_id_hash_allocator.sv
